[rtl/core/assert_macros.svh]
// Assertion macros used by the checker module of the heap block.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, ignored while reset is held.
`define MHPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising edge, reset cycles included.
`define MHPQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/core/mhpq_pkg.sv]
// Package for the min-heap priority queue: payload structs, codes and constants.
// Depends on nothing; used by the top level and the checker.
`timescale 1ns / 1ps

package mhpq_pkg;

  localparam int KEY_W     = 32;
  localparam int CNT_W     = 7;
  localparam int POS_W     = 6;
  localparam int DEPTH_DEF = 64;

  localparam logic [CNT_W-1:0]        CAP_RESET = 7'd64;
  localparam logic signed [KEY_W-1:0] KEY_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [KEY_W-1:0] KEY_MIN   = 32'sh8000_0000;

  typedef enum logic [1:0] {
    ACT_INSERT   = 2'd0,
    ACT_REMOVE   = 2'd1,
    ACT_DECREASE = 2'd2,
    ACT_DELETE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADIDX = 2'd3
  } status_t;

  typedef struct packed {
    action_t                  action;
    logic signed [KEY_W-1:0]  key_value;
    logic [POS_W-1:0]         position;
  } in_item_t;

  typedef struct packed {
    logic signed [KEY_W-1:0]  removed_key;
    status_t                  status;
    logic [CNT_W-1:0]         entry_count;
  } out_item_t;

endpackage

[rtl/core/mhpq_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module mhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/min_heap_priority_queue.sv]
// Binary min-heap priority queue of signed 32-bit keys, stored in one RAM of
// DEPTH words with a single read and a single write port. One operation is
// taken at a time and gives one result. An insert or decrease climbs the key
// one level at a time, fetching each parent; a remove captures the root and
// sinks the last entry from the root (one RAM read per child); a delete is a
// climb followed by a remove. A full, empty or bad-index report goes straight
// to the result, touching no RAM. The result sits in an output register, so
// the next transaction is taken while it waits. The capacity register may be
// written only while the queue is idle; values above DEPTH act as DEPTH. No
// clearing pass runs after reset: only entries below the fill count are ever
// read.
`timescale 1ns / 1ps

module min_heap_priority_queue #(
  parameter int DEPTH = mhpq_pkg::DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  mhpq_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output mhpq_pkg::out_item_t          out_data,
  input  logic                         cfg_we,
  input  logic [mhpq_pkg::CNT_W-1:0]   cfg_wdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = mhpq_pkg::CNT_W;
  localparam int KW = mhpq_pkg::KEY_W;
  localparam logic [CW-1:0] DEPTH_LIM = (DEPTH > 127) ? 7'd127 : 7'(DEPTH);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_UP       = 10'b00_0000_0010,
    S_UP_CMP   = 10'b00_0000_0100,
    S_POP_ROOT = 10'b00_0000_1000,
    S_POP_LAST = 10'b00_0001_0000,
    S_POP_MOVE = 10'b00_0010_0000,
    S_DN_L     = 10'b00_0100_0000,
    S_DN_R     = 10'b00_1000_0000,
    S_DN_CMP   = 10'b01_0000_0000,
    S_FIN      = 10'b10_0000_0000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CW-1:0]           fill_r, fill_nxt;
  logic [CW-1:0]           cap_r;
  logic [CW-1:0]           node_r, node_nxt;
  logic signed [KW-1:0]    key_r, key_nxt;
  logic signed [KW-1:0]    lkey_r, lkey_nxt;
  logic                    rok_r, rok_nxt;
  mhpq_pkg::action_t       act_r, act_nxt;
  logic signed [KW-1:0]    removed_r, removed_nxt;
  mhpq_pkg::status_t       status_r, status_nxt;
  logic                    out_valid_r, out_valid_nxt;
  mhpq_pkg::out_item_t     out_data_r;
  logic                    out_load;

  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [KW-1:0]           ram_wdata;
  logic                    ram_re;
  logic [AW-1:0]           ram_raddr;
  logic [KW-1:0]           ram_rdata;
  logic signed [KW-1:0]    rd_key;

  logic [CW-1:0]           cap_eff;
  logic [CW-1:0]           parent;
  logic [CW:0]             lidx;
  logic [CW:0]             ridx;
  logic                    left_less;
  logic                    right_less;
  logic signed [KW-1:0]    best_key;
  state_t                  after_up;

  // Map a node index onto a RAM address of the storage width.
  function automatic logic [AW-1:0] node_addr(input logic [CW-1:0] n);
    logic [AW+CW-1:0] w;
    w = {{AW{1'b0}}, n};
    return w[AW-1:0];
  endfunction

  mhpq_ram #(
    .WIDTH (KW),
    .DEPTH (DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Tree navigation and compares
  assign rd_key     = $signed(ram_rdata);
  assign cap_eff    = (cap_r > DEPTH_LIM) ? DEPTH_LIM : cap_r;
  assign parent     = 7'(node_r - 7'd1) >> 1;
  assign lidx       = {node_r, 1'b1};
  assign ridx       = {node_r, 1'b0} + 8'd2;
  assign left_less  = lkey_r < key_r;
  assign best_key   = left_less ? lkey_r : key_r;
  assign right_less = rok_r && (rd_key < best_key);
  assign after_up   = (act_r == mhpq_pkg::ACT_DELETE) ? S_POP_ROOT : S_FIN;

  // Sequencer: read, compare and write back one heap level at a time
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    node_nxt      = node_r;
    key_nxt       = key_r;
    lkey_nxt      = lkey_r;
    rok_nxt       = rok_r;
    act_nxt       = act_r;
    removed_nxt   = removed_r;
    status_nxt    = status_r;
    ram_we        = 1'b0;
    ram_waddr     = node_addr(node_r);
    ram_wdata     = key_r;
    ram_re        = 1'b0;
    ram_raddr     = '0;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt     = in_data.action;
          removed_nxt = '0;
          status_nxt  = mhpq_pkg::ST_OK;
          case (in_data.action) inside
            mhpq_pkg::ACT_INSERT: begin
              if (fill_r >= cap_eff) begin
                status_nxt = mhpq_pkg::ST_FULL;
                state_nxt  = S_FIN;
              end else begin
                node_nxt  = fill_r;
                fill_nxt  = fill_r + 7'd1;
                key_nxt   = in_data.key_value;
                state_nxt = S_UP;
              end
            end
            mhpq_pkg::ACT_REMOVE: begin
              if (fill_r == '0) begin
                status_nxt  = mhpq_pkg::ST_EMPTY;
                removed_nxt = mhpq_pkg::KEY_MAX;
                state_nxt   = S_FIN;
              end else begin
                state_nxt = S_POP_ROOT;
              end
            end
            mhpq_pkg::ACT_DECREASE, mhpq_pkg::ACT_DELETE: begin
              if ({1'b0, in_data.position} >= fill_r) begin
                status_nxt = mhpq_pkg::ST_BADIDX;
                state_nxt  = S_FIN;
              end else begin
                node_nxt  = {1'b0, in_data.position};
                key_nxt   = (in_data.action == mhpq_pkg::ACT_DELETE) ?
                            mhpq_pkg::KEY_MIN : in_data.key_value;
                state_nxt = S_UP;
              end
            end
            default: state_nxt = S_FIN;
          endcase
        end
      end

      // Climb: fetch the parent, or drop the key at the root
      S_UP: begin
        if (node_r == '0) begin
          ram_we    = 1'b1;
          state_nxt = after_up;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = node_addr(parent);
          state_nxt = S_UP_CMP;
        end
      end

      // Move the parent down into the hole, or settle the key here
      S_UP_CMP: begin
        ram_we = 1'b1;
        if (key_r < rd_key) begin
          ram_wdata = ram_rdata;
          node_nxt  = parent;
          state_nxt = S_UP;
        end else begin
          state_nxt = after_up;
        end
      end

      S_POP_ROOT: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
        state_nxt = S_POP_LAST;
      end

      // Capture the root, shrink, fetch the last entry
      S_POP_LAST: begin
        if (act_r == mhpq_pkg::ACT_REMOVE) begin
          removed_nxt = rd_key;
        end
        fill_nxt = fill_r - 7'd1;
        if (fill_r == 7'd1) begin
          state_nxt = S_FIN;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = node_addr(fill_r - 7'd1);
          state_nxt = S_POP_MOVE;
        end
      end

      S_POP_MOVE: begin
        key_nxt   = rd_key;
        node_nxt  = '0;
        state_nxt = S_DN_L;
      end

      // Sink: fetch the left child, or settle at a leaf
      S_DN_L: begin
        if (lidx >= {1'b0, fill_r}) begin
          ram_we    = 1'b1;
          state_nxt = S_FIN;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = node_addr(lidx[CW-1:0]);
          state_nxt = S_DN_R;
        end
      end

      // Hold the left key and fetch the right child if present
      S_DN_R: begin
        lkey_nxt = rd_key;
        rok_nxt  = ridx < {1'b0, fill_r};
        if (ridx < {1'b0, fill_r}) begin
          ram_re    = 1'b1;
          ram_raddr = node_addr(ridx[CW-1:0]);
        end
        state_nxt = S_DN_CMP;
      end

      // Pull the smallest child up into the hole, or settle the key
      S_DN_CMP: begin
        ram_we = 1'b1;
        if (right_less) begin
          ram_wdata = ram_rdata;
          node_nxt  = ridx[CW-1:0];
          state_nxt = S_DN_L;
        end else if (left_less) begin
          ram_wdata = lkey_r;
          node_nxt  = lidx[CW-1:0];
          state_nxt = S_DN_L;
        end else begin
          state_nxt = S_FIN;
        end
      end

      // Hand the result to the output register once it is free
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      cap_r       <= mhpq_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  // Working and result registers
  always_ff @(posedge clk) begin
    node_r    <= node_nxt;
    key_r     <= key_nxt;
    lkey_r    <= lkey_nxt;
    rok_r     <= rok_nxt;
    act_r     <= act_nxt;
    removed_r <= removed_nxt;
    status_r  <= status_nxt;
    if (out_load) begin
      out_data_r.removed_key <= removed_r;
      out_data_r.status      <= status_r;
      out_data_r.entry_count <= fill_r;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/core/mhpq_checker.sv]
// Port-level checks for the min-heap priority queue, bound to the top level.
// Depends on mhpq_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mhpq_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input mhpq_pkg::out_item_t         out_data
);

  // Reset empties the result register
  `MHPQ_ASSERT_ALWAYS(a_rst_out, clk, !rst_n |=> !out_valid, "result valid after reset")

  // One operation at a time: a taken transaction closes the input
  `MHPQ_ASSERT(a_one_op, clk, rst_n, in_valid && in_ready |=> !in_ready, "input reopened too soon")

  // A stalled result holds
  `MHPQ_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled result changed")

  // An empty report returns the largest key with nothing held
  `MHPQ_ASSERT(a_empty, clk, rst_n, out_valid && out_data.status == mhpq_pkg::ST_EMPTY |-> out_data.removed_key == mhpq_pkg::KEY_MAX && out_data.entry_count == '0, "bad empty result")

  // A full report returns zero
  `MHPQ_ASSERT(a_full, clk, rst_n, out_valid && out_data.status == mhpq_pkg::ST_FULL |-> out_data.removed_key == '0, "bad full result")

endmodule

bind min_heap_priority_queue mhpq_checker u_mhpq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[sim/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for min_heap_priority_queue: streams heap operations through the
// valid/ready channels and checks every result against a local heap model.
// Depends on mhpq_pkg and the min_heap_priority_queue RTL.

module tb_top;
  import mhpq_pkg::*;

  localparam int HEAP_DEPTH     = DEPTH_DEF;
  localparam int SETTLE_CYCLES  = 60;
  localparam int IDLE_PCT       = 13;
  localparam int HOLD_AT_RESULT = 200;
  localparam int HOLD_CYCLES    = 400;
  localparam int STEADY_FROM    = 450;
  localparam int STEADY_TO      = 600;
  localparam int MAX_PRINTS     = 40;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  in_item_t         in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_data;
  logic             cfg_we    = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;

  // Operations waiting to be sent, and results the heap model predicts
  in_item_t  pending_ops [$];
  out_item_t expected_results [$];

  // Heap model state
  logic signed [KEY_W-1:0] heap_keys [HEAP_DEPTH];
  int                      heap_fill = 0;
  logic [CNT_W-1:0]        heap_cap  = CAP_RESET;

  int mismatch_count = 0;
  int accepted_ops   = 0;
  int results_seen   = 0;
  int hold_left      = 0;
  bit hold_done      = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  min_heap_priority_queue #(.DEPTH(HEAP_DEPTH)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS)
      $display("ERROR t=%0t result %0d: %s", $time, results_seen, msg);
  endtask

  function automatic bit idle_allowed(int n);
    return (n < STEADY_FROM) || (n >= STEADY_TO);
  endfunction

  // ---------------------------------------------------------------------
  // Heap model
  // ---------------------------------------------------------------------
  function automatic void heap_swap(int a, int b);
    logic signed [KEY_W-1:0] t;
    t            = heap_keys[a];
    heap_keys[a] = heap_keys[b];
    heap_keys[b] = t;
  endfunction

  // Move a key toward the root while it is below its parent
  function automatic void heap_climb(int idx);
    int parent;
    while (idx != 0) begin
      parent = (idx - 1) / 2;
      if (heap_keys[idx] >= heap_keys[parent]) break;
      heap_swap(idx, parent);
      idx = parent;
    end
  endfunction

  // Swap with the smallest of node, left child and right child until settled
  function automatic void heap_sink(int idx);
    int lc, rc, best;
    while (1'b1) begin
      lc   = 2 * idx + 1;
      rc   = 2 * idx + 2;
      best = idx;
      if (lc < heap_fill && heap_keys[lc] < heap_keys[best]) best = lc;
      if (rc < heap_fill && heap_keys[rc] < heap_keys[best]) best = rc;
      if (best == idx) break;
      heap_swap(idx, best);
      idx = best;
    end
  endfunction

  function automatic logic signed [KEY_W-1:0] heap_pop();
    logic signed [KEY_W-1:0] root;
    root = heap_keys[0];
    heap_fill--;
    if (heap_fill > 0) begin
      heap_keys[0] = heap_keys[heap_fill];
      heap_sink(0);
    end
    return root;
  endfunction

  // Apply one operation to the model and return the result it should give
  function automatic out_item_t heap_apply(in_item_t op);
    out_item_t res;
    int        cap_eff;
    res.removed_key = '0;
    res.status      = ST_OK;
    cap_eff = (heap_cap > HEAP_DEPTH) ? HEAP_DEPTH : int'(heap_cap);
    case (op.action)
      ACT_INSERT: begin
        if (heap_fill >= cap_eff) begin
          res.status = ST_FULL;
        end else begin
          heap_keys[heap_fill] = op.key_value;
          heap_fill++;
          heap_climb(heap_fill - 1);
        end
      end
      ACT_REMOVE: begin
        if (heap_fill == 0) begin
          res.status      = ST_EMPTY;
          res.removed_key = KEY_MAX;
        end else begin
          res.removed_key = heap_pop();
        end
      end
      ACT_DECREASE: begin
        if (int'(op.position) >= heap_fill) begin
          res.status = ST_BADIDX;
        end else begin
          heap_keys[op.position] = op.key_value;
          heap_climb(op.position);
        end
      end
      default: begin
        if (int'(op.position) >= heap_fill) begin
          res.status = ST_BADIDX;
        end else begin
          heap_keys[op.position] = KEY_MIN;
          heap_climb(op.position);
          void'(heap_pop());
        end
      end
    endcase
    res.entry_count = CNT_W'(heap_fill);
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Input driver
  // ---------------------------------------------------------------------
  // Hold each transaction until accepted, then advance or idle at random
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(heap_apply(in_data));
        accepted_ops++;
      end
      if (!in_valid || in_ready) begin
        if (pending_ops.size() != 0 &&
            !(idle_allowed(accepted_ops) && $urandom_range(99) < IDLE_PCT)) begin
          in_data  <= pending_ops.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result monitor and receiver
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      // Check the accepted result against the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result key %0d status %0d count %0d",
                                    out_data.removed_key, out_data.status,
                                    out_data.entry_count));
        end else begin
          want = expected_results.pop_front();
          if (out_data.removed_key !== want.removed_key)
            report_mismatch($sformatf("removed_key got %0d expected %0d",
                                      out_data.removed_key, want.removed_key));
          if (out_data.status !== want.status)
            report_mismatch($sformatf("status got %0d expected %0d",
                                      out_data.status, want.status));
          if (out_data.entry_count !== want.entry_count)
            report_mismatch($sformatf("entry_count got %0d expected %0d",
                                      out_data.entry_count, want.entry_count));
        end
        results_seen++;
      end
      // Hold off once for a long stretch so the block backs up into its input
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (results_seen == HOLD_AT_RESULT && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(idle_allowed(results_seen) && $urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  task automatic push_op(action_t act, logic signed [KEY_W-1:0] key, int pos);
    in_item_t op;
    op.action    = act;
    op.key_value = key;
    op.position  = POS_W'(pos);
    pending_ops.push_back(op);
  endtask

  function automatic logic signed [KEY_W-1:0] pick_key();
    case ($urandom_range(5))
      0, 1:    return $urandom;
      2, 3:    return $urandom_range(40) - 20;
      4: begin
        case ($urandom_range(3))
          0:       return KEY_MIN;
          1:       return KEY_MAX;
          2:       return -32'sd1;
          default: return '0;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // Queue random ops; the fill count does not depend on key values, so it is
  // tracked exactly here and used to aim most indices inside the heap
  task automatic queue_random_ops(int count);
    int      fill_est, cap_eff, ins_pct, pos;
    action_t act;
    fill_est = heap_fill;
    cap_eff  = (heap_cap > HEAP_DEPTH) ? HEAP_DEPTH : int'(heap_cap);
    ins_pct  = 50;
    for (int n = 0; n < count; n++) begin
      if (n % 60 == 0) begin
        case ($urandom_range(2))
          0:       ins_pct = 80;
          1:       ins_pct = 50;
          default: ins_pct = 20;
        endcase
      end
      if ($urandom_range(99) < ins_pct) begin
        act = ACT_INSERT;
      end else begin
        case ($urandom_range(3))
          0, 1:    act = ACT_REMOVE;
          2:       act = ACT_DECREASE;
          default: act = ACT_DELETE;
        endcase
      end
      if (fill_est > 0 && $urandom_range(9) != 0)
        pos = $urandom_range(fill_est - 1);
      else
        pos = $urandom_range(HEAP_DEPTH - 1);
      push_op(act, pick_key(), pos);
      case (act)
        ACT_INSERT: if (fill_est < cap_eff) fill_est++;
        ACT_REMOVE: if (fill_est > 0) fill_est--;
        ACT_DELETE: if (pos < fill_est) fill_est--;
        default: ;
      endcase
    end
  endtask

  // Wait until every op is sent and every result has come back
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CNT_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    heap_cap = value;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    heap_fill = 0;
    heap_cap  = CAP_RESET;

    // Directed: empty heap, key extremes, every action, bad indices
    write_capacity(7'd64);
    push_op(ACT_REMOVE,   '0, 0);
    push_op(ACT_DECREASE, '0, 0);
    push_op(ACT_DELETE,   '0, 0);
    push_op(ACT_INSERT,   KEY_MAX, 0);
    push_op(ACT_INSERT,   KEY_MIN, 0);
    push_op(ACT_INSERT,   '0, 0);
    push_op(ACT_INSERT,   -32'sd1, 0);
    push_op(ACT_INSERT,   32'sd1, 0);
    push_op(ACT_INSERT,   32'sh4000_0000, 0);
    push_op(ACT_INSERT,   -32'sd100, 0);
    push_op(ACT_DECREASE, -32'sd200, 6);
    // raise the root key: sifts up only, so order below may break
    push_op(ACT_DECREASE, KEY_MAX, 0);
    push_op(ACT_DELETE,   '0, 3);
    push_op(ACT_DELETE,   '0, 0);
    push_op(ACT_DECREASE, 32'sd5, 63);
    push_op(ACT_DELETE,   '0, 5);
    repeat (6) push_op(ACT_REMOVE, '0, 0);
    wait_idle();

    // Small capacity: fill up, then drop the limit below the fill
    write_capacity(7'd2);
    push_op(ACT_INSERT, 32'sd7, 0);
    push_op(ACT_INSERT, -32'sd7, 0);
    push_op(ACT_INSERT, 32'sd3, 0);
    wait_idle();
    write_capacity(7'd0);
    push_op(ACT_INSERT, 32'sd9, 0);
    push_op(ACT_REMOVE, '0, 0);
    wait_idle();

    // Random phases across several capacity settings
    write_capacity(7'd64);
    queue_random_ops(420);
    wait_idle();
    write_capacity(7'd127);
    queue_random_ops(100);
    wait_idle();
    write_capacity(7'd7);
    queue_random_ops(100);
    wait_idle();
    write_capacity(7'd1);
    queue_random_ops(50);
    wait_idle();
    write_capacity(CNT_W'($urandom_range(1, HEAP_DEPTH)));
    queue_random_ops(80);
    wait_idle();

    if (mismatch_count == 0)
      $display("PASS min_heap_priority_queue");
    else
      $display("FAIL min_heap_priority_queue");
    $finish;
  end

  // Watchdog
  initial begin
    #2_400_000;
    $display("FAIL min_heap_priority_queue");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/mhpq_pkg.sv
rtl/core/mhpq_ram.sv
rtl/core/min_heap_priority_queue.sv
rtl/core/mhpq_checker.sv
sim/tb_top.sv
